[rtl/core/dwpid_pkg.sv]
// Package for the dual wheel PID speed control core.
// Holds field widths, operation/direction/register codes, H-bridge patterns, ctrl and gain structs.
// No dependencies.
package dwpid_pkg;

	localparam int COUNT_W = 16;
	localparam int ERR_W   = 17;
	localparam int TOTAL_W = 32;
	localparam int DUTY_W  = 14;
	localparam int GAIN_W  = 16;
	localparam int TGT_W   = 10;
	localparam int TICK_W  = 16;
	localparam int TPS_W   = 8;

	// Largest value a duty register can hold.
	localparam int DUTY_CEIL = 16383;

	localparam logic [1:0] OP_PULSE = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	localparam logic [2:0] DIR_FORWARD = 3'd1;
	localparam logic [2:0] DIR_REVERSE = 3'd2;
	localparam logic [2:0] DIR_LEFT    = 3'd3;
	localparam logic [2:0] DIR_RIGHT   = 3'd4;

	localparam logic [3:0] PAT_FORWARD = 4'd9;
	localparam logic [3:0] PAT_REVERSE = 4'd6;
	localparam logic [3:0] PAT_LEFT    = 4'd8;
	localparam logic [3:0] PAT_RIGHT   = 4'd1;
	localparam logic [3:0] PAT_OFF     = 4'd0;

	localparam logic [2:0] REG_GAIN_P      = 3'd0;
	localparam logic [2:0] REG_GAIN_I      = 3'd1;
	localparam logic [2:0] REG_GAIN_D      = 3'd2;
	localparam logic [2:0] REG_TARGET_SLOW = 3'd3;
	localparam logic [2:0] REG_TARGET_FAST = 3'd4;
	localparam logic [2:0] REG_BASE_LEFT   = 3'd5;
	localparam logic [2:0] REG_BASE_RIGHT  = 3'd6;
	localparam logic [2:0] REG_TICKS_SEC   = 3'd7;

	typedef struct packed {
		logic count;  // encoder pulse item
		logic step;   // run one PID update and clear the count
		logic load;   // load the base duty at move start
		logic clear;  // end of move: clear duty, error history and total
	} wheel_ctrl_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

endpackage

[rtl/core/dual_wheel_pid_speed_control_core.sv]
// Dual wheel PID speed control core: APB register file, move sequencing and two wheel units.
// Depends on dwpid_pkg and dwpid_wheel.
// An accepted item is held in the input register, then applied to the state/result registers.
// Throughput: one item per cycle unless the result stalls; input and result registers overlap.
// The state registers double as the result register, so a stalled result holds the state.
// Reset (arst_n low, asynchronous) clears all state and loads the register defaults.
module dual_wheel_pid_speed_control_core
	import dwpid_pkg::*;
#(
	parameter int PWM_PERIOD         = 10000,
	parameter int GAIN_FRACTION_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] pulse_left, [1] pulse_right, [4:2] move_direction, [5] speed_choice,
	// [13:6] duration_seconds, [15:14] zero
	input  logic [15:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// [13:0] duty_left, [27:14] duty_right, [31:28] bridge_pattern, [32] moving,
	// [33] move_done, [34] ended_by_emergency, [39:35] zero
	output logic [39:0] m_tdata
);

	gains_t             gains_q;
	logic [TGT_W-1:0]   target_slow_q, target_fast_q;
	logic [DUTY_W-1:0]  base_left_q, base_right_q;
	logic [TPS_W-1:0]   ticks_sec_q;

	logic               valid_s1;
	logic [1:0]         op_s1;
	logic               pulse_left_s1, pulse_right_s1;
	logic [2:0]         dir_s1;
	logic               speed_s1;
	logic [7:0]         dur_s1;

	logic [TICK_W-1:0]  ticks_done_q, ticks_limit_q;
	logic               speed_q, stop_req_q, running_q;
	logic [3:0]         pattern_q;
	logic               done_q, emerg_q;
	logic               out_valid_q;

	logic               advance;
	logic               cfg_write;
	logic               end_move, tick_step, end_emerg;
	wheel_ctrl_t        wheel_ctrl;
	logic [TGT_W-1:0]   target;
	logic [DUTY_W-1:0]  duty_left, duty_right;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp    <= 16'd5325;
			gains_q.ki    <= 16'd102;
			gains_q.kd    <= 16'd1024;
			target_slow_q <= 10'd27;
			target_fast_q <= 10'd19;
			base_left_q   <= 14'd5000;
			base_right_q  <= 14'd5500;
			ticks_sec_q   <= 8'd20;
		end else if (cfg_write) begin
			case (paddr[4:2])
				REG_GAIN_P:      gains_q.kp    <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:      gains_q.ki    <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:      gains_q.kd    <= pwdata[GAIN_W-1:0];
				REG_TARGET_SLOW: target_slow_q <= pwdata[TGT_W-1:0];
				REG_TARGET_FAST: target_fast_q <= pwdata[TGT_W-1:0];
				REG_BASE_LEFT:   base_left_q   <= pwdata[DUTY_W-1:0];
				REG_BASE_RIGHT:  base_right_q  <= pwdata[DUTY_W-1:0];
				REG_TICKS_SEC:   ticks_sec_q   <= pwdata[TPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GAIN_P:      prdata = 32'(gains_q.kp);
			REG_GAIN_I:      prdata = 32'(gains_q.ki);
			REG_GAIN_D:      prdata = 32'(gains_q.kd);
			REG_TARGET_SLOW: prdata = 32'(target_slow_q);
			REG_TARGET_FAST: prdata = 32'(target_fast_q);
			REG_BASE_LEFT:   prdata = 32'(base_left_q);
			REG_BASE_RIGHT:  prdata = 32'(base_right_q);
			REG_TICKS_SEC:   prdata = 32'(ticks_sec_q);
			default:         prdata = '0;
		endcase
	end

	// The item in the input register is applied when the result slot is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1          <= s_tuser;
			pulse_left_s1  <= s_tdata[0];
			pulse_right_s1 <= s_tdata[1];
			dir_s1         <= s_tdata[4:2];
			speed_s1       <= s_tdata[5];
			dur_s1         <= s_tdata[13:6];
		end
	end

	always_comb begin
		tick_step  = 1'b0;
		end_move   = 1'b0;
		end_emerg  = 1'b0;
		if (advance && op_s1 == OP_TICK && running_q) begin
			if (stop_req_q) begin
				end_move  = 1'b1;
				end_emerg = 1'b1;
			end else if (ticks_done_q < ticks_limit_q) begin
				tick_step = 1'b1;
			end else begin
				end_move = 1'b1;
			end
		end
		wheel_ctrl.count = advance && op_s1 == OP_PULSE;
		wheel_ctrl.step  = tick_step;
		wheel_ctrl.load  = advance && op_s1 == OP_START;
		wheel_ctrl.clear = end_move;
		target = speed_q ? target_fast_q : target_slow_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_done_q  <= '0;
			ticks_limit_q <= '0;
			speed_q       <= 1'b0;
			stop_req_q    <= 1'b0;
			running_q     <= 1'b0;
			pattern_q     <= PAT_OFF;
			done_q        <= 1'b0;
			emerg_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (m_tready || !out_valid_q) begin
				out_valid_q <= advance;
			end
			if (advance) begin
				done_q  <= end_move;
				emerg_q <= end_emerg;
				if (tick_step) begin
					ticks_done_q <= ticks_done_q + 1'b1;
				end
				if (end_move) begin
					pattern_q  <= PAT_OFF;
					running_q  <= 1'b0;
					stop_req_q <= 1'b0;
				end
				case (op_s1)
					OP_START: begin
						stop_req_q    <= 1'b0;
						speed_q       <= speed_s1;
						ticks_limit_q <= TICK_W'(dur_s1) * TICK_W'(ticks_sec_q);
						ticks_done_q  <= '0;
						running_q     <= 1'b1;
						case (dir_s1)
							DIR_FORWARD: pattern_q <= PAT_FORWARD;
							DIR_REVERSE: pattern_q <= PAT_REVERSE;
							DIR_LEFT:    pattern_q <= PAT_LEFT;
							DIR_RIGHT:   pattern_q <= PAT_RIGHT;
							default: ;
						endcase
					end
					OP_STOP: begin
						stop_req_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	dwpid_wheel #(
		.PWM_PERIOD         (PWM_PERIOD),
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_wheel_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (wheel_ctrl),
		.pulse     (pulse_left_s1),
		.target    (target),
		.base_duty (base_left_q),
		.gains     (gains_q),
		.duty      (duty_left)
	);

	dwpid_wheel #(
		.PWM_PERIOD         (PWM_PERIOD),
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_wheel_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (wheel_ctrl),
		.pulse     (pulse_right_s1),
		.target    (target),
		.base_duty (base_right_q),
		.gains     (gains_q),
		.duty      (duty_right)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, emerg_q, done_q, running_q, pattern_q, duty_right, duty_left};

endmodule

[rtl/core/dwpid_wheel.sv]
// State and PID update for one wheel: pulse count, last error, error total and duty.
// Depends on dwpid_pkg.
module dwpid_wheel
	import dwpid_pkg::*;
#(
	parameter int PWM_PERIOD         = 10000,
	parameter int GAIN_FRACTION_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wheel_ctrl_t       ctrl,
	input  logic              pulse,
	input  logic [TGT_W-1:0]  target,
	input  logic [DUTY_W-1:0] base_duty,
	input  gains_t            gains,
	output logic [DUTY_W-1:0] duty
);

	localparam int ACC_W = 51;
	localparam int SUM_W = ACC_W + 1;
	localparam int DUTY_MAX_I = (PWM_PERIOD < DUTY_CEIL) ? PWM_PERIOD : DUTY_CEIL;
	localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(DUTY_MAX_I);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS =
		ACC_W'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);

	logic [COUNT_W-1:0]        count_q;
	logic signed [ERR_W-1:0]   last_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic [DUTY_W-1:0]         duty_q;

	logic signed [ERR_W-1:0]   err;
	logic signed [ERR_W:0]     err_diff;
	logic signed [GAIN_W:0]    kp_s, ki_s, kd_s;
	logic signed [33:0]        p_term;
	logic signed [34:0]        d_term;
	logic signed [48:0]        i_term;
	logic signed [ACC_W-1:0]   acc, acc_biased, adj;
	logic signed [SUM_W-1:0]   duty_sum;
	logic [DUTY_W-1:0]         duty_new;
	logic signed [TOTAL_W:0]   total_sum;
	logic signed [TOTAL_W-1:0] total_new;
	logic [DUTY_W-1:0]         base_clamped;

	always_comb begin
		err      = $signed(ERR_W'(target)) - $signed({1'b0, count_q});
		err_diff = (ERR_W+1)'(err) - (ERR_W+1)'(last_q);
		kp_s     = $signed({1'b0, gains.kp});
		ki_s     = $signed({1'b0, gains.ki});
		kd_s     = $signed({1'b0, gains.kd});
		p_term   = err * kp_s;
		d_term   = err_diff * kd_s;
		i_term   = total_q * ki_s;
		acc      = ACC_W'(p_term) + ACC_W'(d_term) + ACC_W'(i_term);
		// A negative sum is biased before the arithmetic shift so that it truncates toward zero.
		acc_biased = acc[ACC_W-1] ? (acc + ROUND_BIAS) : acc;
		adj        = acc_biased >>> GAIN_FRACTION_BITS;
		duty_sum   = SUM_W'(adj) + $signed({{(SUM_W-DUTY_W){1'b0}}, duty_q});
		if (duty_sum < 0) begin
			duty_new = '0;
		end else if (duty_sum > $signed({{(SUM_W-DUTY_W){1'b0}}, DUTY_MAX})) begin
			duty_new = DUTY_MAX;
		end else begin
			duty_new = duty_sum[DUTY_W-1:0];
		end
		total_sum = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(err);
		if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1]) begin
			total_new = total_sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
			                               : {1'b0, {(TOTAL_W-1){1'b1}}};
		end else begin
			total_new = total_sum[TOTAL_W-1:0];
		end
		base_clamped = (base_duty > DUTY_MAX) ? DUTY_MAX : base_duty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
			total_q <= '0;
			duty_q  <= '0;
		end else if (ctrl.clear) begin
			last_q  <= '0;
			total_q <= '0;
			duty_q  <= '0;
		end else if (ctrl.load) begin
			duty_q <= base_clamped;
		end else if (ctrl.step) begin
			count_q <= '0;
			last_q  <= err;
			total_q <= total_new;
			duty_q  <= duty_new;
		end else if (ctrl.count && pulse && (count_q != {COUNT_W{1'b1}})) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign duty = duty_q;

endmodule

[test/tb_dual_wheel_pid_speed_control_core.sv]
// Testbench for dual_wheel_pid_speed_control_core: queued item driver, result monitor,
// APB register writes and an in-bench PID predictor checked against every result item.
// Depends on dwpid_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_dual_wheel_pid_speed_control_core;
	import dwpid_pkg::*;

	localparam int PERIOD    = 10000;
	localparam int FRAC      = 12;
	localparam int REG_COUNT = 8;
	localparam int STALL_MAX = 4000;
	localparam int SEG_ITEMS = 300;
	localparam int BURST_LEN = 40;
	localparam longint DUTY_LIMIT = (PERIOD < DUTY_CEIL) ? PERIOD : DUTY_CEIL;
	localparam longint TOTAL_MAX  = (longint'(1) <<< (TOTAL_W - 1)) - 1;
	localparam longint TOTAL_MIN  = -TOTAL_MAX - 1;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] payload;
	} wheel_cmd_t;

	// Same bit layout as m_tdata.
	typedef struct packed {
		logic [4:0]        pad;
		logic              by_emergency;
		logic              done;
		logic              moving;
		logic [3:0]        pattern;
		logic [DUTY_W-1:0] duty_right;
		logic [DUTY_W-1:0] duty_left;
	} wheel_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [0] pulse_left, [1] pulse_right, [4:2] move_direction, [5] speed_choice,
	// [13:6] duration_seconds, [15:14] zero
	logic [15:0] s_tdata = '0;
	// [1:0] operation
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [13:0] duty_left, [27:14] duty_right, [31:28] bridge_pattern, [32] moving,
	// [33] move_done, [34] ended_by_emergency, [39:35] zero
	logic [39:0] m_tdata;

	wheel_cmd_t    pending_cmds[$];
	wheel_status_t status_due[$];

	int tx_idle_pct = 28;
	int rx_idle_pct = 73;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int limit_ends = 0;
	int emergency_ends = 0;
	int settings_used = 1;

	// Predicted register file and core state.
	logic [15:0]              ctl_reg [REG_COUNT] =
		'{16'd5325, 16'd102, 16'd1024, 16'd27, 16'd19, 16'd5000, 16'd5500, 16'd20};
	logic [COUNT_W-1:0]       wheel_pulses  [2] = '{default: '0};
	logic signed [ERR_W-1:0]  wheel_err_prev[2] = '{default: '0};
	logic signed [TOTAL_W-1:0] wheel_err_sum[2] = '{default: '0};
	logic [DUTY_W-1:0]        wheel_duty    [2] = '{default: '0};
	logic [TICK_W-1:0]        tick_count = '0;
	logic [TICK_W-1:0]        tick_limit = '0;
	logic                     fast_speed = 1'b0;
	logic                     halt_pending = 1'b0;
	logic                     in_motion = 1'b0;
	logic [3:0]               bridge = PAT_OFF;

	dual_wheel_pid_speed_control_core #(
		.PWM_PERIOD        (PERIOD),
		.GAIN_FRACTION_BITS(FRAC)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [DUTY_W-1:0] fit_duty(input longint v);
		if (v < 0)
			return '0;
		if (v > DUTY_LIMIT)
			return DUTY_W'(DUTY_LIMIT);
		return DUTY_W'(v);
	endfunction

	// One PID update for a wheel; the integral uses the total from before this tick.
	function automatic void steer_wheel(input int w, input logic [TGT_W-1:0] goal);
		longint e;
		longint acc;
		longint tot;
		e = longint'(goal) - longint'(wheel_pulses[w]);
		acc = longint'(ctl_reg[REG_GAIN_P]) * e
			+ longint'(ctl_reg[REG_GAIN_D]) * (e - longint'(wheel_err_prev[w]))
			+ longint'(ctl_reg[REG_GAIN_I]) * longint'(wheel_err_sum[w]);
		// Signed division truncates toward zero, as the biased arithmetic shift in the wheel does.
		wheel_duty[w] = fit_duty(longint'(wheel_duty[w]) + acc / (longint'(1) <<< FRAC));
		wheel_err_prev[w] = ERR_W'(e);
		tot = longint'(wheel_err_sum[w]) + e;
		if (tot > TOTAL_MAX)
			tot = TOTAL_MAX;
		if (tot < TOTAL_MIN)
			tot = TOTAL_MIN;
		wheel_err_sum[w] = TOTAL_W'(tot);
		wheel_pulses[w] = '0;
	endfunction

	function automatic void finish_move();
		for (int w = 0; w < 2; w++) begin
			wheel_duty[w] = '0;
			wheel_err_prev[w] = '0;
			wheel_err_sum[w] = '0;
		end
		bridge = PAT_OFF;
		in_motion = 1'b0;
		halt_pending = 1'b0;
	endfunction

	// Applies one accepted item to the predicted state and returns the status it yields.
	function automatic wheel_status_t regulate(input logic [1:0] op, input logic [15:0] data);
		wheel_status_t s;
		logic [TGT_W-1:0] goal;
		s = '0;
		case (op)
			OP_PULSE: begin
				for (int w = 0; w < 2; w++)
					if (data[w] && wheel_pulses[w] != '1)
						wheel_pulses[w] = wheel_pulses[w] + 1'b1;
			end
			OP_TICK: begin
				if (in_motion) begin
					if (halt_pending) begin
						finish_move();
						s.done = 1'b1;
						s.by_emergency = 1'b1;
					end else if (tick_count < tick_limit) begin
						goal = fast_speed ? ctl_reg[REG_TARGET_FAST][TGT_W-1:0]
							: ctl_reg[REG_TARGET_SLOW][TGT_W-1:0];
						tick_count = tick_count + 1'b1;
						steer_wheel(0, goal);
						steer_wheel(1, goal);
					end else begin
						finish_move();
						s.done = 1'b1;
					end
				end
			end
			OP_START: begin
				halt_pending = 1'b0;
				case (data[4:2])
					DIR_FORWARD: bridge = PAT_FORWARD;
					DIR_REVERSE: bridge = PAT_REVERSE;
					DIR_LEFT:    bridge = PAT_LEFT;
					DIR_RIGHT:   bridge = PAT_RIGHT;
					default: ;
				endcase
				fast_speed = data[5];
				tick_limit = TICK_W'(data[13:6]) * TICK_W'(ctl_reg[REG_TICKS_SEC][TPS_W-1:0]);
				tick_count = '0;
				wheel_duty[0] = fit_duty(longint'(ctl_reg[REG_BASE_LEFT][DUTY_W-1:0]));
				wheel_duty[1] = fit_duty(longint'(ctl_reg[REG_BASE_RIGHT][DUTY_W-1:0]));
				in_motion = 1'b1;
			end
			default: halt_pending = 1'b1;
		endcase
		s.duty_left = wheel_duty[0];
		s.duty_right = wheel_duty[1];
		s.pattern = bridge;
		s.moving = in_motion;
		return s;
	endfunction

	function automatic wheel_cmd_t make_cmd(input logic [1:0] op, input logic pl, input logic pr,
			input logic [2:0] dir, input logic spd, input logic [7:0] dur);
		wheel_cmd_t c;
		c.op = op;
		c.payload = {2'b00, dur, spd, dir, pr, pl};
		return c;
	endfunction

	function automatic wheel_cmd_t random_cmd(input logic [1:0] op);
		wheel_cmd_t c;
		c.op = op;
		c.payload = {2'b00, 14'($urandom)};
		return c;
	endfunction

	task automatic note_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= 20)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Item driver: holds each item until it is accepted, then predicts its status.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				status_due.push_back(regulate(s_tuser, s_tdata));
				void'(pending_cmds.pop_front());
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_cmds[0].op;
					s_tdata <= pending_cmds[0].payload;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure and periodic long hold-offs.
	int hold_left = 0;
	always @(posedge clk) begin
		wheel_status_t want;
		wheel_status_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (status_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result item, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = status_due.pop_front();
					note_field("duty_left", want.duty_left, got.duty_left);
					note_field("duty_right", want.duty_right, got.duty_right);
					note_field("bridge_pattern", want.pattern, got.pattern);
					note_field("moving", want.moving, got.moving);
					note_field("move_done", want.done, got.done);
					note_field("ended_by_emergency", want.by_emergency, got.by_emergency);
					note_field("padding", want.pad, got.pad);
				end
				if (got.done)
					if (got.by_emergency)
						emergency_ends++;
					else
						limit_ends++;
				results_seen++;
				// Long stall while the sender keeps offering, so the core backs up.
				if (results_seen % 700 == 350)
					hold_left = 160;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_MAX) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_MAX);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		ctl_reg[idx] = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Kind 0 writes zero to every register but ticks per second (1), kind 1 high values, others random.
	task automatic load_setting(input int kind);
		logic [15:0] v [REG_COUNT];
		if (kind == 0) begin
			v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
		end else if (kind == 1) begin
			// The left base duty lies above the period and must be clamped on load.
			v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1023, 16'd1023, 16'd16383, 16'd10000,
				16'd255};
		end else begin
			v[REG_GAIN_P] = 16'($urandom_range(0, 12000));
			v[REG_GAIN_I] = 16'($urandom_range(0, 400));
			v[REG_GAIN_D] = 16'($urandom_range(0, 6000));
			v[REG_TARGET_SLOW] = 16'($urandom_range(0, 40));
			v[REG_TARGET_FAST] = 16'($urandom_range(0, 40));
			v[REG_BASE_LEFT] = 16'($urandom_range(0, PERIOD));
			v[REG_BASE_RIGHT] = 16'($urandom_range(0, PERIOD));
			v[REG_TICKS_SEC] = 16'($urandom_range(1, 12));
		end
		for (int i = 0; i < REG_COUNT; i++)
			reg_write(3'(i), v[i]);
		settings_used++;
	endtask

	// Mostly whole control periods (a run of pulses, then a tick), plus starts,
	// emergency stops and some fully random noise.
	task automatic fill_segment(input int n);
		int count;
		int r;
		int burst;
		wheel_cmd_t c;
		count = 0;
		while (count < n) begin
			r = $urandom_range(99);
			if (r < 70) begin
				burst = $urandom_range(0, 45);
				repeat (burst) pending_cmds.push_back(random_cmd(OP_PULSE));
				pending_cmds.push_back(random_cmd(OP_TICK));
				count += burst + 1;
			end else if (r < 82) begin
				c = random_cmd(OP_START);
				if ($urandom_range(3) != 0)
					c.payload[13:6] = 8'($urandom_range(0, 3));
				pending_cmds.push_back(c);
				count++;
			end else if (r < 88) begin
				pending_cmds.push_back(random_cmd(OP_STOP));
				pending_cmds.push_back(random_cmd(OP_TICK));
				count += 2;
			end else begin
				pending_cmds.push_back(random_cmd(2'($urandom)));
				count++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part with the reset register values.
		@(negedge clk);
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));      // tick while idle
		pending_cmds.push_back(make_cmd(OP_STOP, 0, 0, 0, 0, 0));      // emergency while idle
		pending_cmds.push_back(make_cmd(OP_PULSE, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_PULSE, 1, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_PULSE, 0, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_PULSE, 1, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, DIR_FORWARD, 0, 8'd255));
		pending_cmds.push_back(make_cmd(OP_PULSE, 1, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, 3'd0, 1, 8'd1)); // restart, keep pattern
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, DIR_REVERSE, 0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));      // zero limit ends it
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, DIR_LEFT, 1, 8'd2));
		pending_cmds.push_back(make_cmd(OP_STOP, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));      // ends by emergency
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, DIR_RIGHT, 0, 8'd1));
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, 3'd5, 0, 8'd1));
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, 3'd6, 1, 8'd1));
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, 3'd7, 0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
		drain();

		// A run of pulses on both wheels, then two ticks and an emergency stop.
		@(negedge clk);
		pending_cmds.push_back(make_cmd(OP_START, 0, 0, DIR_FORWARD, 1, 8'd255));
		repeat (BURST_LEN) pending_cmds.push_back(make_cmd(OP_PULSE, 1, 1, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_STOP, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
		drain();

		// Random part: two segments per idling pattern, each under a new register setting.
		for (int seg = 0; seg < 6; seg++) begin
			load_setting(seg);
			@(negedge clk);
			case (seg / 2)
				0: begin
					tx_idle_pct = 28;
					rx_idle_pct = 73;
				end
				1: begin
					tx_idle_pct = 73;
					rx_idle_pct = 28;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			fill_segment(SEG_ITEMS);
			drain();
		end
		repeat (10) @(posedge clk);

		$display("Covered %0d items and %0d results under %0d register settings",
			items_sent, results_seen, settings_used);
		$display("and three idling patterns; moves ended at the limit: %0d, by emergency: %0d.",
			limit_ends, emergency_ends);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
